// ----- src/sqrs_pkg.sv -----
// Shared constants for the square-root rate shaper.
package sqrs_pkg;

	localparam int ERR_W          = 16;
	localparam int TIME_W         = 16;
	localparam int ACC_W          = 16;
	localparam int RATE_W         = 21;
	localparam int OUT_FRAC_DEF   = 12;
	localparam int APB_AW         = 2;
	localparam int APB_DW         = 32;

	localparam logic [ACC_W-1:0]  ACC_RST        = 16'd2560;
	localparam logic [APB_AW-1:0] REG_ACCEL_LIMIT = 2'd0;

	// 1e12, 2e12 / 2^12 and 1e6
	localparam logic [39:0] TERA_C = 40'd1000000000000;
	localparam logic [28:0] LHS_C  = 29'd488281250;
	localparam logic [19:0] MEGA_C = 20'd1000000;

endpackage

// ----- src/sqrt_rate_shaper_unit.sv -----
// Square-root rate shaper: pipelined rate reference from angle error and step time.
// Stages from input accept to out_valid: 4 setup stages, one init
// stage, 22 bit stages of the square root and the clamp divider, one output stage.
// Throughput: one item per cycle; each stage advances when the next one is free.
// Reset: arst_n clears all valid bits and loads accel_limit with 10.0 rad/s^2.
module sqrt_rate_shaper_unit #(
	parameter int OUT_FRAC_BITS = sqrs_pkg::OUT_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [sqrs_pkg::ERR_W-1:0]  angle_error,
	input  logic [sqrs_pkg::TIME_W-1:0]     step_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [sqrs_pkg::RATE_W-1:0] rate_ref,
	output logic                            saturated,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sqrs_pkg::APB_AW-1:0]     paddr,
	input  logic [sqrs_pkg::APB_DW-1:0]     pwdata,
	output logic [sqrs_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	localparam int F    = OUT_FRAC_BITS;
	localparam int OW   = sqrs_pkg::RATE_W;
	localparam int NI   = OW + 1;
	localparam int SR   = (2 * F > 20) ? 2 * F - 20 : 0;
	localparam int SL   = (2 * F < 20) ? 20 - 2 * F : 0;
	localparam int LW   = 57;
	localparam int RW   = sqrs_pkg::ACC_W + LW + SR;
	localparam int KW   = 41 + SL;
	localparam int RKW  = KW + OW;
	localparam int WW   = ((RW > RKW + OW + 1) ? RW : RKW + OW + 1) + 1;
	localparam int NW   = 35 + F;
	localparam int DW   = ((NW > 16 + 12 + NI) ? NW : 16 + 12 + NI) + 1;
	localparam logic [KW-1:0] K_C = KW'(sqrs_pkg::TERA_C) << SL;
	localparam logic [NI-1:0] POS_MAX = NI'((1 << (OW - 1)) - 1);
	localparam logic [NI-1:0] NEG_MAG = NI'(1 << (OW - 1));

	// configuration
	logic [sqrs_pkg::ACC_W-1:0] accel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= sqrs_pkg::ACC_RST;
		end else if (psel && penable && pwrite && paddr == sqrs_pkg::REG_ACCEL_LIMIT) begin
			accel_q <= pwdata[sqrs_pkg::ACC_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == sqrs_pkg::REG_ACCEL_LIMIT) ?
		sqrs_pkg::APB_DW'(accel_q) : '0;

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, out_vld_q;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_out;
	logic [NI:0] it_vld_s;
	logic [NI:0] it_adv;

	always_comb begin
		adv_out = !out_vld_q || out_ready;
		it_adv[NI] = !it_vld_s[NI] || adv_out;
		for (int k = NI - 1; k >= 0; k--) begin
			it_adv[k] = !it_vld_s[k] || it_adv[k+1];
		end
		adv_s4 = !v_s4 || it_adv[0];
		adv_s3 = !v_s3 || adv_s4;
		adv_s2 = !v_s2 || adv_s3;
		adv_s1 = !v_s1 || adv_s2;
	end

	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			it_vld_s <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (it_adv[0]) it_vld_s[0] <= v_s4;
			for (int k = 0; k < NI; k++) begin
				if (it_adv[k+1]) it_vld_s[k+1] <= it_vld_s[k];
			end
			if (adv_out) out_vld_q <= it_vld_s[NI];
		end
	end

	// stage 1: magnitude and first products
	logic        neg_s1;
	logic [15:0] mag_s1;
	logic [15:0] t_s1, a_s1;
	logic [31:0] tt_s1;
	logic [44:0] ml_s1;
	logic [34:0] nm_s1;
	logic [15:0] mag_in;

	assign mag_in = angle_error[15] ? (~angle_error + 16'd1) : angle_error;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			neg_s1 <= angle_error[15];
			mag_s1 <= mag_in;
			t_s1   <= step_time;
			a_s1   <= accel_q;
			tt_s1  <= 32'(step_time) * 32'(step_time);
			ml_s1  <= 45'(mag_in) * 45'(sqrs_pkg::LHS_C);
			nm_s1  <= 35'(mag_in) * 35'(sqrs_pkg::MEGA_C);
		end
	end

	// stage 2: both sides of the threshold
	logic          neg_s2, mnz_s2;
	logic [15:0]   t_s2, a_s2;
	logic [LW-1:0] lhs_s2, rhs_s2;
	logic [34:0]   nm_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			neg_s2 <= neg_s1;
			mnz_s2 <= mag_s1 != '0;
			t_s2   <= t_s1;
			a_s2   <= a_s1;
			lhs_s2 <= {ml_s1, 12'd0};
			rhs_s2 <= LW'(48'(a_s1) * 48'(tt_s1)) << 4;
			nm_s2  <= nm_s1;
		end
	end

	// stage 3: threshold test and difference
	logic          neg_s3, go_s3, tnz_s3;
	logic [15:0]   a_s3;
	logic [LW-1:0] td_s3;
	logic [DW-1:0] num_s3, den_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			neg_s3 <= neg_s2;
			go_s3  <= mnz_s2 && (lhs_s2 > rhs_s2);
			td_s3  <= lhs_s2 - rhs_s2;
			a_s3   <= a_s2;
			tnz_s3 <= t_s2 != '0;
			num_s3 <= DW'(nm_s2) << F;
			den_s3 <= DW'(t_s2) << 12;
		end
	end

	// stage 4: radicand partial products, clamp range check
	logic          neg_s4, go_s4, clok_s4;
	logic [44:0]   pl_s4;
	logic [43:0]   ph_s4;
	logic [DW-1:0] num_s4, den_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			neg_s4  <= neg_s3;
			go_s4   <= go_s3;
			pl_s4   <= 45'(a_s3) * 45'(td_s3[28:0]);
			ph_s4   <= 44'(a_s3) * 44'(td_s3[LW-1:29]);
			num_s4  <= num_s3;
			den_s4  <= den_s3;
			clok_s4 <= tnz_s3 && (num_s3 < (den_s3 << NI));
		end
	end

	// bit stages: index 0 is the init stage, k+1 holds the result of bit NI-1-k
	logic [WW-1:0]  it_rem_s  [0:NI];
	logic [RKW-1:0] it_rk_s   [0:NI];
	logic [OW-1:0]  it_r_s    [0:NI];
	logic [DW-1:0]  it_drem_s [0:NI];
	logic [NI-1:0]  it_q_s    [0:NI];
	logic [DW-1:0]  it_den_s  [0:NI];
	logic           it_neg_s  [0:NI];
	logic           it_go_s   [0:NI];
	logic           it_clok_s [0:NI];

	always_ff @(posedge clk) begin
		if (it_adv[0]) begin
			it_rem_s[0]  <= WW'(RW'(73'({ph_s4, 29'd0}) + 73'(pl_s4)) << SR);
			it_rk_s[0]   <= '0;
			it_r_s[0]    <= '0;
			it_drem_s[0] <= num_s4;
			it_q_s[0]    <= '0;
			it_den_s[0]  <= den_s4;
			it_neg_s[0]  <= neg_s4;
			it_go_s[0]   <= go_s4;
			it_clok_s[0] <= clok_s4;
		end
	end

	for (genvar k = 0; k < NI; k++) begin : g_bit
		localparam int B = NI - 1 - k;
		logic [WW-1:0] delta;
		logic [DW-1:0] dsub;
		logic          sq_take, d_take;

		assign delta   = (WW'(it_rk_s[k]) << (B + 1)) + (WW'(K_C) << (2 * B));
		assign sq_take = (B < OW) && (it_rem_s[k] >= delta);
		assign dsub    = it_den_s[k] << B;
		assign d_take  = it_drem_s[k] >= dsub;

		always_ff @(posedge clk) begin
			if (it_adv[k+1]) begin
				it_rem_s[k+1]  <= sq_take ? it_rem_s[k] - delta : it_rem_s[k];
				it_rk_s[k+1]   <= sq_take ? it_rk_s[k] + (RKW'(K_C) << B) : it_rk_s[k];
				it_r_s[k+1]    <= sq_take ? it_r_s[k] | (OW'(1) << B) : it_r_s[k];
				it_drem_s[k+1] <= d_take ? it_drem_s[k] - dsub : it_drem_s[k];
				it_q_s[k+1]    <= d_take ? it_q_s[k] | (NI'(1) << B) : it_q_s[k];
				it_den_s[k+1]  <= it_den_s[k];
				it_neg_s[k+1]  <= it_neg_s[k];
				it_go_s[k+1]   <= it_go_s[k];
				it_clok_s[k+1] <= it_clok_s[k];
			end
		end
	end

	// output stage: clamp, saturate, apply sign
	logic [NI-1:0] r_ext, m_pre, m_lim;
	logic [OW-1:0] m_out;
	logic          sat_c;
	logic signed [OW-1:0] rate_q;
	logic          sat_q;

	always_comb begin
		r_ext = NI'(it_r_s[NI]);
		if (!it_go_s[NI]) begin
			m_pre = '0;
		end else if (it_clok_s[NI] && it_q_s[NI] < r_ext) begin
			m_pre = it_q_s[NI];
		end else begin
			m_pre = r_ext;
		end
		m_lim = it_neg_s[NI] ? NEG_MAG : POS_MAX;
		sat_c = m_pre > m_lim;
		m_out = sat_c ? m_lim[OW-1:0] : m_pre[OW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			rate_q <= it_neg_s[NI] ? -$signed(m_out) : $signed(m_out);
			sat_q  <= sat_c;
		end
	end

	assign out_valid = out_vld_q;
	assign rate_ref  = rate_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item missing from first stage");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			rate_ref == $signed(POS_MAX[OW-1:0]) || rate_ref == $signed(NEG_MAG[OW-1:0]))
		else $error("saturated rate not at range limit");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		it_vld_s[NI] && !it_go_s[NI] && adv_out |=> rate_ref == '0 && !saturated)
		else $error("rate nonzero below threshold");
`endif

endmodule

// ----- tb/sqrt_rate_shaper_unit_chk.sv -----
// Checker for the square-root rate shaper: predicts each rate item and compares it.
`timescale 1ns / 1ps
module sqrt_rate_shaper_unit_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [sqrs_pkg::ERR_W-1:0]  angle_error,
	input  logic [sqrs_pkg::TIME_W-1:0]        step_time,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [sqrs_pkg::RATE_W-1:0] rate_ref,
	input  logic                               saturated,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [sqrs_pkg::APB_AW-1:0]        paddr,
	input  logic [sqrs_pkg::APB_DW-1:0]        pwdata,
	output int                                 fails,
	output int                                 pending
);
	localparam int FRAC = sqrs_pkg::OUT_FRAC_DEF;

	typedef struct packed {
		logic signed [sqrs_pkg::RATE_W-1:0] rate;
		logic                               sat;
	} rate_item_t;

	rate_item_t                 rate_q[$];
	logic [sqrs_pkg::ACC_W-1:0] accel;

	function automatic rate_item_t shape_rate(logic signed [sqrs_pkg::ERR_W-1:0] err,
			logic [sqrs_pkg::TIME_W-1:0] t, logic [sqrs_pkg::ACC_W-1:0] a);
		rate_item_t  res;
		logic        neg;
		logic [63:0] mag, lhs, rhs, tdiff, cl, m;
		logic [127:0] right, left, c, r;
		neg   = err[sqrs_pkg::ERR_W-1];
		mag   = neg ? 64'(-int'(err)) : 64'(int'(err));
		lhs   = mag * 64'd2 * 64'd1000000000000;
		rhs   = 64'd16 * 64'(a) * 64'(t) * 64'(t);
		m     = '0;
		res.sat = 1'b0;
		if (mag != 0 && lhs > rhs) begin
			tdiff = lhs - rhs;
			right = (128'(a) * 128'(tdiff)) << (2 * FRAC - 20);
			r = '0;
			for (int b = sqrs_pkg::RATE_W - 1; b >= 0; b--) begin
				c = r | (128'd1 << b);
				left = c * c * 128'd1000000000000;
				if (left <= right)
					r = c;
			end
			m = 64'(r);
			if (t != 0) begin
				cl = (mag * 64'd1000000 * (64'd1 << FRAC)) / (64'd4096 * 64'(t));
				if (cl < m)
					m = cl;
			end
		end
		if (!neg) begin
			if (m > 64'd1048575) begin
				m = 64'd1048575;
				res.sat = 1'b1;
			end
			res.rate = sqrs_pkg::RATE_W'(m);
		end else begin
			if (m > 64'd1048576) begin
				m = 64'd1048576;
				res.sat = 1'b1;
			end
			res.rate = sqrs_pkg::RATE_W'(-m);
		end
		return res;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	assign pending = rate_q.size();

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		rate_item_t want;
		if (!arst_n) begin
			accel <= sqrs_pkg::ACC_RST;
			rate_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == sqrs_pkg::REG_ACCEL_LIMIT)
				accel <= pwdata[sqrs_pkg::ACC_W-1:0];
			if (in_valid && in_ready)
				rate_q.push_back(shape_rate(angle_error, step_time, accel));
			if (out_valid && out_ready) begin
				if (rate_q.size() == 0) begin
					report("unexpected item, rate_ref", int'(rate_ref), 0);
				end else begin
					want = rate_q.pop_front();
					if (rate_ref !== want.rate)
						report("rate_ref", int'(rate_ref), int'(want.rate));
					if (saturated !== want.sat)
						report("saturated", int'(saturated), int'(want.sat));
				end
			end
		end
	end
endmodule

// ----- tb/sqrt_rate_shaper_unit_tb.sv -----
// Testbench top for the square-root rate shaper: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module sqrt_rate_shaper_unit_tb;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [sqrs_pkg::ERR_W-1:0]  angle_error = '0;
	logic [sqrs_pkg::TIME_W-1:0]        step_time = 16'd1;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic signed [sqrs_pkg::RATE_W-1:0] rate_ref;
	logic                               saturated;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [sqrs_pkg::APB_AW-1:0]        paddr = '0;
	logic [sqrs_pkg::APB_DW-1:0]        pwdata = '0;
	logic [sqrs_pkg::APB_DW-1:0]        prdata;
	logic                               pready;
	int                                 fails;
	int                                 pending;
	int                                 cycles = 0;
	logic                               no_gaps = 1'b0;

	always #6 clk = ~clk;

	sqrt_rate_shaper_unit dut (.*);

	sqrt_rate_shaper_unit_chk chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			n = no_gaps ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic write_accel(logic [sqrs_pkg::ACC_W-1:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= sqrs_pkg::REG_ACCEL_LIMIT;
		pwdata  <= sqrs_pkg::APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_error(logic signed [sqrs_pkg::ERR_W-1:0] err,
			logic [sqrs_pkg::TIME_W-1:0] t);
		int n;
		n = no_gaps ? 0 : $urandom_range(0, 16);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		angle_error <= err;
		step_time   <= t;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_random(int count);
		logic [sqrs_pkg::TIME_W-1:0] t;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: t = sqrs_pkg::TIME_W'($urandom_range(1, 65535));
				1: t = sqrs_pkg::TIME_W'($urandom_range(1, 20));
				default: t = sqrs_pkg::TIME_W'($urandom_range(1, 3000));
			endcase
			send_error(sqrs_pkg::ERR_W'($urandom), t);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		logic [sqrs_pkg::ACC_W-1:0] accel_set[5];
		accel_set = '{16'd0, 16'd65535, 16'd1, 16'd256, 16'd2560};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_error(16'sd0, 16'd1);
		send_error(16'sd32767, 16'd1);
		send_error(-16'sd32768, 16'd1);
		send_error(16'sd1, 16'd1);
		send_error(-16'sd1, 16'd1);
		send_error(16'sd32767, 16'd65535);
		send_error(-16'sd32768, 16'd65535);
		send_error(16'sd4096, 16'd100);
		send_error(-16'sd4096, 16'd100);
		send_error(16'sd4096, 16'd0);
		send_error(-16'sd32768, 16'd0);
		send_error(16'sd0, 16'd0);
		send_error(16'sd1234, 16'd5000);
		send_error(-16'sd20000, 16'd20000);
		send_random(120);
		drain();

		foreach (accel_set[k]) begin
			write_accel(accel_set[k]);
			send_error(16'sd32767, 16'd1);
			send_error(-16'sd32768, 16'd0);
			send_error(16'sd100, 16'd65535);
			send_random(k == 4 ? 140 : 100);
			drain();
		end
		write_accel(sqrs_pkg::ACC_W'($urandom));
		send_random(60);
		drain();

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/sqrs_pkg.sv
src/sqrt_rate_shaper_unit.sv
tb/sqrt_rate_shaper_unit_chk.sv
tb/sqrt_rate_shaper_unit_tb.sv
